[src/twbs_pkg.sv]
// shared types and constants for the two-wire bus status sequencer
package twbs_pkg;

  localparam int unsigned FifoDepthDefault = 64;

  localparam logic [2:0] KIND_STATUS  = 3'd0;
  localparam logic [2:0] KIND_TARGET  = 3'd1;
  localparam logic [2:0] KIND_GO      = 3'd2;
  localparam logic [2:0] KIND_PUSH_MT = 3'd3;
  localparam logic [2:0] KIND_PUSH_ST = 3'd4;
  localparam logic [2:0] KIND_POP_MR  = 3'd5;
  localparam logic [2:0] KIND_POP_SR  = 3'd6;

  localparam logic [7:0] STATUS_MASK = 8'hF8;

  // classified item handed from front to back
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  status;
    logic [7:0]  bus_data;
    logic [6:0]  target_address;
    logic        read_flag;
    logic [15:0] request_count;
    logic [7:0]  tx_byte;
  } item_t;

endpackage

[src/two_wire_bus_status_sequencer.sv]
// top level of the two-wire bus status sequencer
// each input transfer reaches its result through the queue, ram read and execute steps
// the back end works on one item at a time and takes no new item until its result
//   has been taken, because each item may read a fifo ram with a registered read
// the front queue holds two items so input transfers continue while a result waits
// reset (rst_ni low, asynchronous): fifos empty, target, length, count and busy flags zero
module two_wire_bus_status_sequencer #(
  parameter int unsigned FIFO_DEPTH = twbs_pkg::FifoDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  bus_status_i,
  input  logic [7:0]  bus_data_i,
  input  logic [6:0]  target_address_i,
  input  logic        read_flag_i,
  input  logic [15:0] request_count_i,
  input  logic [7:0]  tx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        drive_start_o,
  output logic        drive_stop_o,
  output logic        drive_ack_o,
  output logic        drive_valid_o,
  output logic [7:0]  bus_byte_out_o,
  output logic        bus_byte_load_o,
  output logic [7:0]  read_byte_o,
  output logic        read_valid_o,
  output logic        accepted_o,
  output logic        master_busy_o,
  output logic        slave_busy_o,
  output logic [15:0] master_count_o
);
  import twbs_pkg::*;

  item_t in_item, q_item;
  logic  q_valid, q_pop;

  // pack the input transfer
  assign in_item = '{kind: kind_i, status: bus_status_i, bus_data: bus_data_i,
                     target_address: target_address_i, read_flag: read_flag_i,
                     request_count: request_count_i, tx_byte: tx_byte_i};

  twbs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_item_o   (q_item)
  );

  twbs_back #(.FifoDepth(FIFO_DEPTH)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_pop_o         (q_pop),
    .q_item_i        (q_item),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .drive_start_o   (drive_start_o),
    .drive_stop_o    (drive_stop_o),
    .drive_ack_o     (drive_ack_o),
    .drive_valid_o   (drive_valid_o),
    .bus_byte_out_o  (bus_byte_out_o),
    .bus_byte_load_o (bus_byte_load_o),
    .read_byte_o     (read_byte_o),
    .read_valid_o    (read_valid_o),
    .accepted_o      (accepted_o),
    .master_busy_o   (master_busy_o),
    .slave_busy_o    (slave_busy_o),
    .master_count_o  (master_count_o)
  );
endmodule

[src/twbs_ram.sv]
// generic single-port-write ram with registered read
module twbs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[src/twbs_front.sv]
// front end: input skid queue of two entries holding masked items
module twbs_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  twbs_pkg::item_t       in_item_i,
  output logic                  q_valid_o,
  input  logic                  q_pop_i,
  output twbs_pkg::item_t       q_item_o
);
  import twbs_pkg::*;

  item_t      buf_q [2];
  logic       rd_q, rd_d, wr_q, wr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  item_t      cls;

  always_comb begin
    cls = in_item_i;
    cls.status = in_item_i.status & STATUS_MASK;
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = buf_q[rd_q];

  always_comb begin
    rd_d  = rd_q ^ q_pop_i;
    wr_d  = wr_q ^ push;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= cls;
  end
endmodule

[src/twbs_back.sv]
// back end: fifo state, status handling and result register
module twbs_back #(
  parameter int unsigned FifoDepth = twbs_pkg::FifoDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  output logic            q_pop_o,
  input  twbs_pkg::item_t q_item_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            drive_start_o,
  output logic            drive_stop_o,
  output logic            drive_ack_o,
  output logic            drive_valid_o,
  output logic [7:0]      bus_byte_out_o,
  output logic            bus_byte_load_o,
  output logic [7:0]      read_byte_o,
  output logic            read_valid_o,
  output logic            accepted_o,
  output logic            master_busy_o,
  output logic            slave_busy_o,
  output logic [15:0]     master_count_o
);
  import twbs_pkg::*;

  localparam int unsigned AW = $clog2(FifoDepth);
  localparam int unsigned CW = $clog2(FifoDepth + 1);
  localparam logic [CW-1:0] Full = CW'(FifoDepth);
  localparam int unsigned NF = 4; // 0 mt, 1 mr, 2 st, 3 sr

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]    state_q, state_d;
  item_t         it_q;
  logic [AW-1:0] head_q [NF];
  logic [CW-1:0] cnt_q  [NF];
  logic [7:0]    adir_q;
  logic [15:0]   rlen_q, tcnt_q;
  logic          mact_q, sact_q;

  logic [NF-1:0] we;
  logic [AW-1:0] waddr [NF];
  logic [7:0]    wdata [NF];
  logic [7:0]    rdata [NF];
  logic [AW-1:0] wsum  [NF];

  // result register
  logic        r_st_q, r_sp_q, r_ack_q, r_val_q, r_load_q, r_rv_q, r_acc_q;
  logic [7:0]  r_bout_q, r_rb_q;
  logic        ov_q;

  // decode helpers in the exec cycle
  logic [1:0]  pop_sel, push_sel;
  logic        do_pop, do_push;
  logic [7:0]  push_val;
  logic        clr_mt;
  logic        st, sp, ack, vld, load, rv, acc;
  logic [7:0]  bout, rb;
  logic        mact_d, sact_d;
  logic [15:0] tcnt_d;
  logic [15:0] tinc;
  logic [7:0]  adir_d;
  logic [15:0] rlen_d;
  logic        pop_ok, push_ok;

  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;

  for (genvar g = 0; g < NF; g++) begin : g_fifo
    assign wsum[g]  = head_q[g] + cnt_q[g][AW-1:0];
    assign waddr[g] = (FifoDepth == (1 << AW)) ? wsum[g] :
                      ((32'(head_q[g]) + 32'(cnt_q[g]) >= FifoDepth) ?
                        AW'(32'(head_q[g]) + 32'(cnt_q[g]) - FifoDepth) : wsum[g]);
    assign wdata[g] = push_val;
    assign we[g]    = (state_q == S_READ) && do_push && push_ok && (push_sel == 2'(g));
    twbs_ram #(.Width(8), .Depth(FifoDepth)) u_ram (
      .clk_i   (clk_i),
      .we_i    (we[g]),
      .waddr_i (waddr[g]),
      .wdata_i (wdata[g]),
      .raddr_i (head_q[g]),
      .rdata_o (rdata[g])
    );
  end

  assign tinc = (tcnt_q != 16'hFFFF) ? tcnt_q + 16'd1 : tcnt_q;

  always_comb begin
    st = 1'b0; sp = 1'b0; ack = 1'b0; vld = 1'b0; load = 1'b0;
    rv = 1'b0; acc = 1'b0; bout = 8'd0; rb = 8'd0;
    mact_d = mact_q; sact_d = sact_q; tcnt_d = tcnt_q;
    adir_d = adir_q; rlen_d = rlen_q; clr_mt = 1'b0;
    do_pop = 1'b0; pop_sel = 2'd0; do_push = 1'b0; push_sel = 2'd0;
    push_val = it_q.tx_byte;
    pop_ok = (cnt_q[pop_sel] != '0);
    push_ok = 1'b0;
    case (it_q.kind)
      KIND_STATUS: begin
        vld = 1'b1; ack = 1'b1; push_val = it_q.bus_data;
        case (it_q.status)
          8'h08, 8'h10: begin
            bout = adir_q; load = 1'b1; tcnt_d = 16'd0;
          end
          8'h18, 8'h28: begin
            do_pop = 1'b1; pop_sel = 2'd0;
            pop_ok = (cnt_q[0] != '0);
            if (pop_ok) begin
              bout = rdata[0]; load = 1'b1; tcnt_d = tinc;
            end else begin
              sp = 1'b1; mact_d = 1'b0;
            end
          end
          8'h20, 8'h30, 8'h48, 8'h58: begin
            sp = 1'b1; mact_d = 1'b0;
          end
          8'h40: ;
          8'h50: begin
            do_push = 1'b1; push_sel = 2'd1;
            tcnt_d = tinc;
            ack = (tinc < rlen_q);
          end
          8'h60, 8'h70: sact_d = 1'b1;
          8'h80, 8'h90: begin
            do_push = 1'b1; push_sel = 2'd3;
          end
          8'h88, 8'h98: begin
            do_push = 1'b1; push_sel = 2'd3; sact_d = 1'b0;
          end
          8'hA0, 8'hC0, 8'hC8: sact_d = 1'b0;
          8'h68, 8'h78: ack = 1'b0;
          8'hA8, 8'hB0, 8'hB8: begin
            if (it_q.status != 8'hB8) sact_d = 1'b1;
            do_pop = 1'b1; pop_sel = 2'd2;
            pop_ok = (cnt_q[2] != '0);
            if (pop_ok) begin
              bout = rdata[2]; load = 1'b1;
            end else begin
              ack = 1'b0;
            end
          end
          8'h38: st = 1'b1;
          default: sp = 1'b1;
        endcase
      end
      KIND_TARGET: begin
        if (it_q.read_flag) begin
          adir_d = {it_q.target_address, 1'b1};
          rlen_d = it_q.request_count;
        end else begin
          adir_d = {it_q.target_address, 1'b0};
          clr_mt = 1'b1;
        end
      end
      KIND_GO: begin
        if (!mact_q && !sact_q) begin
          mact_d = 1'b1; st = 1'b1; ack = 1'b1; vld = 1'b1; acc = 1'b1;
        end
      end
      KIND_PUSH_MT: begin
        do_push = 1'b1; push_sel = 2'd0;
      end
      KIND_PUSH_ST: begin
        do_push = 1'b1; push_sel = 2'd2;
      end
      KIND_POP_MR: begin
        do_pop = 1'b1; pop_sel = 2'd1;
        pop_ok = (cnt_q[1] != '0);
        rv = pop_ok; rb = pop_ok ? rdata[1] : 8'd0;
      end
      KIND_POP_SR: begin
        do_pop = 1'b1; pop_sel = 2'd3;
        pop_ok = (cnt_q[3] != '0);
        rv = pop_ok; rb = pop_ok ? rdata[3] : 8'd0;
      end
      default: ;
    endcase
    push_ok = (cnt_q[push_sel] != Full);
    if (it_q.kind == KIND_PUSH_MT || it_q.kind == KIND_PUSH_ST) acc = push_ok;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (q_valid_i) state_d = S_READ;
      S_READ:  state_d = S_OUT;
      S_OUT:   if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
      adir_q  <= 8'd0;
      rlen_q  <= 16'd0;
      tcnt_q  <= 16'd0;
      mact_q  <= 1'b0;
      sact_q  <= 1'b0;
      for (int i = 0; i < NF; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == S_READ) begin
        ov_q   <= 1'b1;
        adir_q <= adir_d;
        rlen_q <= rlen_d;
        tcnt_q <= tcnt_d;
        mact_q <= mact_d;
        sact_q <= sact_d;
        if (do_pop && pop_ok) begin
          head_q[pop_sel] <= (32'(head_q[pop_sel]) == FifoDepth - 1) ? '0
                             : head_q[pop_sel] + AW'(1);
          cnt_q[pop_sel]  <= cnt_q[pop_sel] - CW'(1);
        end
        if (do_push && push_ok) cnt_q[push_sel] <= cnt_q[push_sel] + CW'(1);
        if (clr_mt) begin
          head_q[0] <= '0;
          cnt_q[0]  <= '0;
        end
      end else if (state_q == S_OUT && !out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) it_q <= q_item_i;
    if (state_q == S_READ) begin
      r_st_q <= st; r_sp_q <= sp; r_ack_q <= ack; r_val_q <= vld;
      r_load_q <= load; r_rv_q <= rv; r_acc_q <= acc;
      r_bout_q <= bout; r_rb_q <= rb;
    end
  end

  assign drive_start_o   = r_st_q;
  assign drive_stop_o    = r_sp_q;
  assign drive_ack_o     = r_ack_q;
  assign drive_valid_o   = r_val_q;
  assign bus_byte_out_o  = r_bout_q;
  assign bus_byte_load_o = r_load_q;
  assign read_byte_o     = r_rb_q;
  assign read_valid_o    = r_rv_q;
  assign accepted_o      = r_acc_q;
  assign master_busy_o   = mact_q;
  assign slave_busy_o    = sact_q;
  assign master_count_o  = tcnt_q;
endmodule

[verif/tb_two_wire_bus_status_sequencer.sv]
// testbench for the two-wire bus status sequencer: queued stimulus, predictor, result checks
module tb_two_wire_bus_status_sequencer;
  import twbs_pkg::*;

  // bus status codes after masking the low three bits
  localparam logic [7:0] ST_START            = 8'h08;
  localparam logic [7:0] ST_REP_START        = 8'h10;
  localparam logic [7:0] ST_MT_ADDR_ACK      = 8'h18;
  localparam logic [7:0] ST_MT_ADDR_NACK     = 8'h20;
  localparam logic [7:0] ST_MT_DATA_ACK      = 8'h28;
  localparam logic [7:0] ST_MT_DATA_NACK     = 8'h30;
  localparam logic [7:0] ST_ARB_LOST         = 8'h38;
  localparam logic [7:0] ST_MR_ADDR_ACK      = 8'h40;
  localparam logic [7:0] ST_MR_ADDR_NACK     = 8'h48;
  localparam logic [7:0] ST_MR_DATA_ACK      = 8'h50;
  localparam logic [7:0] ST_MR_DATA_NACK     = 8'h58;
  localparam logic [7:0] ST_SR_ADDR          = 8'h60;
  localparam logic [7:0] ST_SR_ARB_ADDR      = 8'h68;
  localparam logic [7:0] ST_SR_GEN           = 8'h70;
  localparam logic [7:0] ST_SR_ARB_GEN       = 8'h78;
  localparam logic [7:0] ST_SR_DATA_ACK      = 8'h80;
  localparam logic [7:0] ST_SR_DATA_NACK     = 8'h88;
  localparam logic [7:0] ST_SR_GEN_DATA_ACK  = 8'h90;
  localparam logic [7:0] ST_SR_GEN_DATA_NACK = 8'h98;
  localparam logic [7:0] ST_SR_STOP          = 8'hA0;
  localparam logic [7:0] ST_ST_ADDR          = 8'hA8;
  localparam logic [7:0] ST_ST_ARB_ADDR      = 8'hB0;
  localparam logic [7:0] ST_ST_DATA_ACK      = 8'hB8;
  localparam logic [7:0] ST_ST_DATA_NACK     = 8'hC0;
  localparam logic [7:0] ST_ST_LAST_ACK      = 8'hC8;
  localparam logic [7:0] ST_UNKNOWN          = 8'hF8;
  localparam logic [7:0] ST_NONE             = 8'h00;

  localparam logic [2:0] KIND_UNUSED = 3'd7;

  // predictor fifo indexes
  localparam int MTX = 0;
  localparam int MRX = 1;
  localparam int STX = 2;
  localparam int SRX = 3;
  localparam int DEPTH = FifoDepthDefault;

  localparam int QUIET_TAIL = 80;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic        start;
    logic        stop;
    logic        ack;
    logic        dvalid;
    logic [7:0]  bout;
    logic        load;
    logic [7:0]  rbyte;
    logic        rvalid;
    logic        acc;
    logic        mbusy;
    logic        sbusy;
    logic [15:0] count;
  } bus_result_t;

  logic clk, rst_ni;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [2:0] kind;
  logic [7:0] bus_status, bus_data, tx_byte;
  logic [6:0] target_address;
  logic read_flag;
  logic [15:0] request_count;
  bus_result_t got;

  two_wire_bus_status_sequencer u_top (
    .clk_i(clk), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .kind_i(kind), .bus_status_i(bus_status), .bus_data_i(bus_data),
    .target_address_i(target_address), .read_flag_i(read_flag),
    .request_count_i(request_count), .tx_byte_i(tx_byte),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .drive_start_o(got.start), .drive_stop_o(got.stop), .drive_ack_o(got.ack),
    .drive_valid_o(got.dvalid), .bus_byte_out_o(got.bout),
    .bus_byte_load_o(got.load), .read_byte_o(got.rbyte),
    .read_valid_o(got.rvalid), .accepted_o(got.acc),
    .master_busy_o(got.mbusy), .slave_busy_o(got.sbusy),
    .master_count_o(got.count)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // predictor state
  logic [7:0]  fifo_mem [4][DEPTH];
  int          fifo_head [4];
  int          fifo_cnt [4];
  logic [7:0]  addr_dir;
  logic [15:0] req_len;
  logic [15:0] xfer_cnt;
  logic        m_active, s_active;

  item_t       pending_items [$];
  bus_result_t expected_results [$];
  int          mismatches;
  int          results_seen;
  logic        quiet;
  logic        hold_off;

  function automatic bit fifo_put(int f, logic [7:0] v);
    if (fifo_cnt[f] >= DEPTH) return 1'b0;
    fifo_mem[f][(fifo_head[f] + fifo_cnt[f]) % DEPTH] = v;
    fifo_cnt[f]++;
    return 1'b1;
  endfunction

  function automatic bit fifo_take(int f, output logic [7:0] v);
    v = 8'd0;
    if (fifo_cnt[f] == 0) return 1'b0;
    v = fifo_mem[f][fifo_head[f]];
    fifo_head[f] = (fifo_head[f] + 1) % DEPTH;
    fifo_cnt[f]--;
    return 1'b1;
  endfunction

  function automatic void bump_count();
    if (xfer_cnt != 16'hFFFF) xfer_cnt++;
  endfunction

  // works out the bus controls for one transfer and advances the predictor state
  function automatic bus_result_t bus_controls(item_t it);
    bus_result_t r;
    logic [7:0] s;
    logic [7:0] b;
    r = '0;
    s = it.status & STATUS_MASK;
    case (it.kind)
      KIND_STATUS: begin
        r.dvalid = 1'b1;
        r.ack = 1'b1;
        case (s)
          ST_START, ST_REP_START: begin
            r.bout = addr_dir; r.load = 1'b1; xfer_cnt = '0;
          end
          ST_MT_ADDR_ACK, ST_MT_DATA_ACK: begin
            if (fifo_take(MTX, b)) begin
              r.bout = b; r.load = 1'b1; bump_count();
            end else begin
              r.stop = 1'b1; m_active = 1'b0;
            end
          end
          ST_MT_ADDR_NACK, ST_MT_DATA_NACK, ST_MR_ADDR_NACK, ST_MR_DATA_NACK: begin
            r.stop = 1'b1; m_active = 1'b0;
          end
          ST_MR_ADDR_ACK: ;
          ST_MR_DATA_ACK: begin
            void'(fifo_put(MRX, it.bus_data));
            bump_count();
            r.ack = xfer_cnt < req_len;
          end
          ST_SR_ADDR, ST_SR_GEN: s_active = 1'b1;
          ST_SR_DATA_ACK, ST_SR_GEN_DATA_ACK: void'(fifo_put(SRX, it.bus_data));
          ST_SR_DATA_NACK, ST_SR_GEN_DATA_NACK: begin
            void'(fifo_put(SRX, it.bus_data)); s_active = 1'b0;
          end
          ST_SR_STOP, ST_ST_DATA_NACK, ST_ST_LAST_ACK: s_active = 1'b0;
          ST_SR_ARB_ADDR, ST_SR_ARB_GEN: r.ack = 1'b0;
          ST_ST_ADDR, ST_ST_ARB_ADDR, ST_ST_DATA_ACK: begin
            if (s != ST_ST_DATA_ACK) s_active = 1'b1;
            if (fifo_take(STX, b)) begin
              r.bout = b; r.load = 1'b1;
            end else begin
              r.ack = 1'b0;
            end
          end
          ST_ARB_LOST: r.start = 1'b1;
          default: r.stop = 1'b1;
        endcase
      end
      KIND_TARGET: begin
        if (it.read_flag) begin
          addr_dir = {it.target_address, 1'b1};
          req_len = it.request_count;
        end else begin
          addr_dir = {it.target_address, 1'b0};
          fifo_head[MTX] = 0;
          fifo_cnt[MTX] = 0;
        end
      end
      KIND_GO: begin
        if (!m_active && !s_active) begin
          m_active = 1'b1;
          r.start = 1'b1; r.ack = 1'b1; r.dvalid = 1'b1; r.acc = 1'b1;
        end
      end
      KIND_PUSH_MT: r.acc = fifo_put(MTX, it.tx_byte);
      KIND_PUSH_ST: r.acc = fifo_put(STX, it.tx_byte);
      KIND_POP_MR: r.rvalid = fifo_take(MRX, r.rbyte);
      KIND_POP_SR: r.rvalid = fifo_take(SRX, r.rbyte);
      default: ;
    endcase
    r.mbusy = m_active;
    r.sbusy = s_active;
    r.count = xfer_cnt;
    return r;
  endfunction

  task automatic report(string field, logic [15:0] seen, logic [15:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", field, seen, want, $time);
    mismatches++;
  endtask

  // item with every field random, then the kind forced
  function automatic item_t rand_item(logic [2:0] k);
    item_t it;
    it.kind = k;
    it.status = 8'($urandom);
    it.bus_data = 8'($urandom);
    it.target_address = 7'($urandom);
    it.read_flag = 1'($urandom);
    it.request_count = 16'($urandom);
    it.tx_byte = 8'($urandom);
    return it;
  endfunction

  task automatic add(logic [2:0] k);
    pending_items.push_back(rand_item(k));
  endtask

  // status event; low bits are noise the block must ignore
  task automatic add_status(logic [7:0] code);
    item_t it;
    it = rand_item(KIND_STATUS);
    it.status = code | 8'($urandom_range(0, 7));
    pending_items.push_back(it);
  endtask

  task automatic add_target(logic rd, logic [15:0] len);
    item_t it;
    it = rand_item(KIND_TARGET);
    it.read_flag = rd;
    it.request_count = len;
    pending_items.push_back(it);
  endtask

  task automatic add_go_or_arb();
    // mostly a clean start, sometimes arbitration loss first
    if ($urandom_range(0, 7) == 0) add_status(ST_ARB_LOST);
    add(KIND_GO);
  endtask

  // driver: one nonblocking write per signal per edge
  int idle_in;
  always @(posedge clk or negedge rst_ni) begin
    item_t it;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      kind <= '0; bus_status <= '0; bus_data <= '0; target_address <= '0;
      read_flag <= 1'b0; request_count <= '0; tx_byte <= '0;
      idle_in = 0;
      quiet <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        it = '{kind, bus_status, bus_data, target_address, read_flag,
               request_count, tx_byte};
        expected_results.push_back(bus_controls(it));
      end
      quiet <= pending_items.size() < QUIET_TAIL;
      if (!(in_valid && in_stall)) begin
        if (idle_in > 0) begin
          idle_in--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          it = pending_items.pop_front();
          kind <= it.kind; bus_status <= it.status; bus_data <= it.bus_data;
          target_address <= it.target_address; read_flag <= it.read_flag;
          request_count <= it.request_count; tx_byte <= it.tx_byte;
          in_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 9) == 0) idle_in = $urandom_range(1, 16);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall bursts plus the long hold-off
  int stall_left;
  always @(posedge clk or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (stall_left > 0) stall_left--;
      else if (!quiet && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 16);
      out_stall <= hold_off || (stall_left > 0);
    end
  end

  // monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    bus_result_t want;
    if (rst_ni && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("unexpected result transfer at %0t", $time);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (got.start !== want.start) report("drive_start", got.start, want.start);
        if (got.stop !== want.stop) report("drive_stop", got.stop, want.stop);
        if (got.ack !== want.ack) report("drive_ack", got.ack, want.ack);
        if (got.dvalid !== want.dvalid) report("drive_valid", got.dvalid, want.dvalid);
        if (got.bout !== want.bout) report("bus_byte_out", got.bout, want.bout);
        if (got.load !== want.load) report("bus_byte_load", got.load, want.load);
        if (got.rbyte !== want.rbyte) report("read_byte", got.rbyte, want.rbyte);
        if (got.rvalid !== want.rvalid) report("read_valid", got.rvalid, want.rvalid);
        if (got.acc !== want.acc) report("accepted", got.acc, want.acc);
        if (got.mbusy !== want.mbusy) report("master_busy", got.mbusy, want.mbusy);
        if (got.sbusy !== want.sbusy) report("slave_busy", got.sbusy, want.sbusy);
        if (got.count !== want.count) report("master_count", got.count, want.count);
      end
    end
  end

  // watchdog on cycles without any transfer
  int idle_cycles;
  always @(posedge clk) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL two_wire_bus_status_sequencer");
        $finish;
      end
    end
  end

  // long receiver hold-off so the front queue fills and input stalls
  initial begin
    int n;
    hold_off = 1'b0;
    while (results_seen < 50) @(posedge clk);
    hold_off <= 1'b1;
    for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    int n, i, j, plain;
    mismatches = 0;
    results_seen = 0;
    idle_cycles = 0;
    for (i = 0; i < 4; i++) begin
      fifo_head[i] = 0;
      fifo_cnt[i] = 0;
    end
    addr_dir = '0; req_len = '0; xfer_cnt = '0;
    m_active = 1'b0; s_active = 1'b0;

    // directed: empty pops, go and go while busy, empty tx, odd codes, unused kind
    add(KIND_POP_MR);
    add(KIND_POP_SR);
    add(KIND_GO);
    add(KIND_GO);
    add_status(ST_START);
    add_status(ST_MT_ADDR_ACK);
    add_status(ST_UNKNOWN);
    add_status(ST_NONE);
    add_status(ST_MR_ADDR_ACK);
    add_status(ST_ARB_LOST);
    add_status(ST_SR_ARB_ADDR);
    add_status(ST_SR_ARB_GEN);
    add_status(ST_ST_ARB_ADDR);
    add_status(ST_ST_DATA_NACK);
    add(KIND_UNUSED);
    add_target(1'b1, 16'hFFFF);
    add_target(1'b1, 16'h0000);
    add(KIND_PUSH_MT);
    add(KIND_PUSH_ST);
    add_target(1'b0, 16'h0000);
    add_status(ST_MT_DATA_ACK);
    add_status(ST_SR_STOP);

    // random sequences, mostly well-formed transfers with random content
    plain = 0;
    while (plain < 600) begin
      n = pending_items.size();
      case ($urandom_range(0, 9))
        0, 1: begin // master write
          add_target(1'b0, 16'($urandom));
          j = $urandom_range(0, 6);
          for (i = 0; i < j; i++) add(KIND_PUSH_MT);
          add_go_or_arb();
          add_status($urandom_range(0, 3) == 0 ? ST_REP_START : ST_START);
          add_status(ST_MT_ADDR_ACK);
          for (i = 0; i < j + $urandom_range(0, 1); i++)
            add_status($urandom_range(0, 6) == 0 ? ST_MT_DATA_NACK : ST_MT_DATA_ACK);
          if ($urandom_range(0, 3) == 0) add_status(ST_MT_ADDR_NACK);
        end
        2, 3: begin // master read
          add_target(1'b1, 16'($urandom_range(0, 6)));
          add_go_or_arb();
          add_status(ST_START);
          if ($urandom_range(0, 5) == 0) add_status(ST_MR_ADDR_NACK);
          else begin
            add_status(ST_MR_ADDR_ACK);
            j = $urandom_range(0, 6);
            for (i = 0; i < j; i++) add_status(ST_MR_DATA_ACK);
            add_status(ST_MR_DATA_NACK);
          end
          j = $urandom_range(0, 8);
          for (i = 0; i < j; i++) add(KIND_POP_MR);
        end
        4, 5: begin // slave receive
          add_status($urandom_range(0, 1) ? ST_SR_ADDR : ST_SR_GEN);
          j = $urandom_range(0, 6);
          for (i = 0; i < j; i++)
            add_status($urandom_range(0, 1) ? ST_SR_DATA_ACK : ST_SR_GEN_DATA_ACK);
          case ($urandom_range(0, 2))
            0: add_status(ST_SR_DATA_NACK);
            1: add_status(ST_SR_GEN_DATA_NACK);
            default: add_status(ST_SR_STOP);
          endcase
          j = $urandom_range(0, 8);
          for (i = 0; i < j; i++) add(KIND_POP_SR);
        end
        6, 7: begin // slave transmit
          j = $urandom_range(0, 6);
          for (i = 0; i < j; i++) add(KIND_PUSH_ST);
          add_status($urandom_range(0, 1) ? ST_ST_ADDR : ST_ST_ARB_ADDR);
          for (i = 0; i < j + $urandom_range(0, 1); i++) add_status(ST_ST_DATA_ACK);
          add_status($urandom_range(0, 1) ? ST_ST_DATA_NACK : ST_ST_LAST_ACK);
        end
        8: begin // noise
          j = $urandom_range(1, 10);
          for (i = 0; i < j; i++) add(3'($urandom));
        end
        default: begin // overfill a fifo
          case ($urandom_range(0, 3))
            0: for (i = 0; i < DEPTH + 3; i++) add(KIND_PUSH_ST);
            1: for (i = 0; i < DEPTH + 3; i++) add(KIND_PUSH_MT);
            2: for (i = 0; i < DEPTH + 3; i++) add_status(ST_SR_DATA_ACK);
            default: for (i = 0; i < DEPTH + 3; i++) add_status(ST_MR_DATA_ACK);
          endcase
        end
      endcase
      plain += pending_items.size() - n;
    end

    rst_ni = 1'b0;
    repeat (5) @(posedge clk);
    rst_ni <= 1'b1;

    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS two_wire_bus_status_sequencer");
    end else begin
      $display("FAIL two_wire_bus_status_sequencer");
    end
    $finish;
  end

endmodule

[sim.f]
src/twbs_pkg.sv
src/twbs_ram.sv
src/twbs_front.sv
src/twbs_back.sv
src/two_wire_bus_status_sequencer.sv
verif/tb_two_wire_bus_status_sequencer.sv
